@@ design/ffsa_pkg.sv @@
// Package for the first-fit segment allocator.
// Holds the function codes, status codes, controller state type, cell operation type and reset size.
// No dependencies.
package ffsa_pkg;

	typedef enum logic [1:0] {
		FN_ALLOC   = 2'd0,
		FN_FREE    = 2'd1,
		FN_COMPACT = 2'd2,
		FN_NONE    = 2'd3
	} func_t;

	typedef enum logic [2:0] {
		ST_OK    = 3'd0,
		ST_SHORT = 3'd1,
		ST_FRAG  = 3'd2,
		ST_NOID  = 3'd3,
		ST_FULL  = 3'd4,
		ST_TABLE = 3'd5
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_FREE2,
		S_PACK,
		S_DONE
	} state_t;

	// Operation that every cell applies in the same cycle.
	typedef enum logic [2:0] {
		OP_HOLD,
		OP_INIT,
		OP_ALLOC,
		OP_FREE,
		OP_MERGE,
		OP_PACK,
		OP_TAIL
	} cell_op_t;

	localparam logic [15:0] RESET_SIZE = 16'd500;

endpackage

@@ design/first_fit_segment_allocator.sv @@
// Top level of the first-fit segment allocator: control sequencer and a
// row of ffsa_cell table entries. Depends on ffsa_pkg and ffsa_cell.
//
//  channel  | handshake          | payload
//  ---------+--------------------+-----------------------------------
//  cfg      | cfg_valid/cfg_ready| cfg_data (total_memory_size)
//  in       | in_valid/in_stall  | func, proc_id, req_size
//  out      | out_valid/out_stall| status, seg_start, free_total
//
// Allocate scans the table one step per entry, then applies one table update
// and gives its result; free scans, releases the entry and tries two merges
// (right, then left); compact reads and packs one entry per cycle, writes the
// free tail and gives its result. An allocate rejected as too short, a compact
// with no free space and an unknown function go straight to the result. The
// entry scan sets the rate.
// Reset loads a single free segment of 500 units; no clearing pass.
// A result waits in the output register while out_stall is high; the next
// item and any size write are taken only once it has left.
module first_fit_segment_allocator import ffsa_pkg::*; #(
	parameter int MAX_SEGMENTS = 16,
	parameter int ID_WIDTH     = 16,
	parameter int ADDR_WIDTH   = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  func,
	input  logic [15:0] proc_id,
	input  logic [15:0] req_size,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic [15:0] seg_start,
	output logic [15:0] free_total
);

	localparam int IW = $clog2(MAX_SEGMENTS);
	localparam int CW = $clog2(MAX_SEGMENTS + 1);
	localparam logic [CW-1:0] MAXC = CW'(MAX_SEGMENTS);

	logic [ADDR_WIDTH-1:0] start_v [MAX_SEGMENTS];
	logic [ADDR_WIDTH-1:0] len_v   [MAX_SEGMENTS];
	logic [ID_WIDTH-1:0]   owner_v [MAX_SEGMENTS];
	logic                  used_v  [MAX_SEGMENTS];

	state_t                state_q, state_d;
	cell_op_t              op;
	logic [CW-1:0]         count_q;
	logic [ADDR_WIDTH-1:0] free_q;
	logic [CW-1:0]         scan_q;   // scan/read pointer
	logic [CW-1:0]         wp_q;     // compaction write pointer
	logic [ADDR_WIDTH-1:0] addr_q;   // compaction running address
	logic [IW-1:0]         k_q;
	logic                  found_q;
	logic [1:0]            func_q;
	logic [ID_WIDTH-1:0]   pid_q;
	logic [ADDR_WIDTH-1:0] req_q;
	logic                  out_v_q;
	status_t               st_q;
	logic [ADDR_WIDTH-1:0] sstart_q;
	logic                  step_q;   // free: 0 right merge, 1 left merge
	logic                  split;
	logic                  table_full;
	logic                  alloc_short;

	logic [IW-1:0] scan_i;
	assign scan_i = scan_q[IW-1:0];

	assign cfg_ready  = (state_q == S_IDLE) && !out_v_q;
	assign in_stall   = (state_q != S_IDLE) || out_v_q || cfg_valid;
	assign out_valid  = out_v_q;
	assign status     = st_q;
	assign seg_start  = 16'(sstart_q);
	assign free_total = 16'(free_q);

	assign split       = (len_v[k_q] != req_q);
	assign table_full  = split && (count_q >= MAXC);
	assign alloc_short = (req_size == 16'd0) || (ADDR_WIDTH'(req_size) > free_q);

	logic hit;
	always_comb begin
		if (func_q == FN_ALLOC)
			hit = !used_v[scan_i] && (len_v[scan_i] >= req_q);
		else
			hit = used_v[scan_i] && (owner_v[scan_i] == pid_q);
	end

	// Free merge selection: step 0 merges k with k+1, step 1 merges k-1 with k.
	logic [IW-1:0] msel;
	logic          do_merge;
	always_comb begin
		msel = k_q;
		do_merge = 1'b0;
		if (!step_q) begin
			do_merge = (CW'(k_q) + 1'b1 < count_q) && !used_v[IW'(k_q + 1'b1)];
		end else if (k_q != '0) begin
			msel = k_q - 1'b1;
			do_merge = !used_v[msel];
		end
	end

	logic pack_hit;
	assign pack_hit = (scan_q < count_q) && used_v[scan_i];

	always_comb begin
		state_d = state_q;
		op = OP_HOLD;
		case (state_q)
			S_IDLE: begin
				if (cfg_valid && cfg_ready) begin
					op = OP_INIT;
				end else if (in_valid && !in_stall) begin
					case (func)
						FN_ALLOC: state_d = alloc_short ? S_DONE : S_SCAN;
						FN_FREE: state_d = S_SCAN;
						FN_COMPACT: state_d = (free_q == '0) ? S_DONE : S_PACK;
						default: state_d = S_DONE;
					endcase
				end
			end
			S_SCAN: begin
				// The cycle after a hit applies the table update for entry k.
				if (found_q) begin
					if (func_q == FN_FREE) begin
						op = OP_FREE;
						state_d = S_FREE2;
					end else begin
						if (!table_full) op = OP_ALLOC;
						state_d = S_DONE;
					end
				end else if (scan_q >= count_q) begin
					state_d = S_DONE;
				end
			end
			S_FREE2: begin
				if (do_merge) op = OP_MERGE;
				if (step_q) state_d = S_DONE;
			end
			S_PACK: begin
				if (scan_q < count_q) begin
					if (pack_hit) op = OP_PACK;
				end else begin
					op = OP_TAIL;
					state_d = S_DONE;
				end
			end
			S_DONE: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// Per-cell selection for the shared op.
	logic [IW-1:0] sel_idx;
	always_comb begin
		sel_idx = k_q;
		if (op == OP_MERGE) sel_idx = msel;
	end

	for (genvar g = 0; g < MAX_SEGMENTS; g++) begin : g_cell
		localparam int L = (g == 0) ? 0 : g - 1;
		localparam int R = (g == MAX_SEGMENTS - 1) ? g : g + 1;
		ffsa_cell #(.IDX(g), .ID_WIDTH(ID_WIDTH), .ADDR_WIDTH(ADDR_WIDTH)) u_cell (
			.clk, .arst_n,
			.op(op),
			.init_len(ADDR_WIDTH'(cfg_data)),
			.sel(sel_idx == IW'(g)),
			.right_of_sel(IW'(g) > sel_idx),
			.split(split),
			.req(req_q),
			.pid(pid_q),
			.pack_wr(wp_q == CW'(g)),
			.pack_start(addr_q),
			.pack_len(len_v[scan_i]),
			.pack_owner(owner_v[scan_i]),
			.tail_wr(wp_q == CW'(g)),
			.tail_len(free_q),
			.l_start(start_v[L]), .l_len(len_v[L]),
			.l_owner(owner_v[L]), .l_used(used_v[L]),
			.l_sel((g != 0) && (sel_idx == IW'(L))),
			.r_start(start_v[R]), .r_len(len_v[R]),
			.r_owner(owner_v[R]), .r_used(used_v[R] && (g != MAX_SEGMENTS - 1)),
			.start_q(start_v[g]), .len_q(len_v[g]),
			.owner_q(owner_v[g]), .used_q(used_v[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= CW'(1);
			free_q   <= RESET_SIZE[ADDR_WIDTH-1:0];
			out_v_q  <= 1'b0;
			found_q  <= 1'b0;
			step_q   <= 1'b0;
			scan_q   <= '0;
			wp_q     <= '0;
			addr_q   <= '0;
			k_q      <= '0;
			func_q   <= FN_ALLOC;
			pid_q    <= '0;
			req_q    <= '0;
			st_q     <= ST_OK;
			sstart_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == S_DONE)
				out_v_q <= 1'b1;
			else if (out_v_q && !out_stall)
				out_v_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (cfg_valid && cfg_ready) begin
						count_q <= (cfg_data == 16'd0) ? CW'(0) : CW'(1);
						free_q  <= ADDR_WIDTH'(cfg_data);
					end else if (in_valid && !in_stall) begin
						func_q   <= func;
						pid_q    <= ID_WIDTH'(proc_id);
						req_q    <= ADDR_WIDTH'(req_size);
						scan_q   <= '0;
						found_q  <= 1'b0;
						step_q   <= 1'b0;
						wp_q     <= '0;
						addr_q   <= '0;
						sstart_q <= '0;
						case (func)
							FN_ALLOC: st_q <= alloc_short ? ST_SHORT : ST_OK;
							FN_COMPACT: st_q <= (free_q == '0) ? ST_FULL : ST_OK;
							default: st_q <= ST_OK;
						endcase
					end
				end
				S_SCAN: begin
					if (found_q) begin
						if (func_q == FN_FREE) begin
							free_q <= free_q + len_v[k_q];
						end else if (table_full) begin
							st_q <= ST_TABLE;
						end else begin
							if (split) count_q <= count_q + 1'b1;
							free_q   <= free_q - req_q;
							sstart_q <= start_v[k_q];
						end
					end else if (scan_q >= count_q) begin
						st_q <= (func_q == FN_ALLOC) ? ST_FRAG : ST_NOID;
					end else if (hit) begin
						found_q <= 1'b1;
						k_q     <= scan_i;
					end else
						scan_q <= scan_q + 1'b1;
				end
				S_FREE2: begin
					step_q <= 1'b1;
					if (do_merge) count_q <= count_q - 1'b1;
				end
				S_PACK: begin
					if (scan_q < count_q) begin
						scan_q <= scan_q + 1'b1;
						if (pack_hit) begin
							wp_q   <= wp_q + 1'b1;
							addr_q <= addr_q + len_v[scan_i];
						end
					end else
						count_q <= wp_q + 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	// A waiting result holds its payload until it is taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status) && $stable(seg_start)
			&& $stable(free_total));

	// No item is taken while an operation is running.
	a_busy_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> in_stall);

	// The table never holds more entries than it has cells.
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= MAXC);

	// Every result carries a defined status code.
	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status <= ST_TABLE));

	// A size write is only offered a slot when no result is waiting.
	a_cfg_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready |-> !out_valid);

endmodule

@@ design/ffsa_cell.sv @@
// One entry of the segment table and its share of the per-item work.
// Depends on ffsa_pkg. Takes its left neighbor's entry for split shifts, its right neighbor's for merges.
module ffsa_cell import ffsa_pkg::*; #(
	parameter int IDX        = 0,
	parameter int ID_WIDTH   = 16,
	parameter int ADDR_WIDTH = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cell_op_t              op,
	input  logic [ADDR_WIDTH-1:0] init_len,
	input  logic                  sel,          // this cell is the chosen entry (k, or k-1 on a left merge)
	input  logic                  right_of_sel, // index > chosen entry
	input  logic                  split,
	input  logic [ADDR_WIDTH-1:0] req,
	input  logic [ID_WIDTH-1:0]   pid,
	input  logic                  pack_wr,      // compaction writes this cell now
	input  logic [ADDR_WIDTH-1:0] pack_start,
	input  logic [ADDR_WIDTH-1:0] pack_len,
	input  logic [ID_WIDTH-1:0]   pack_owner,
	input  logic                  tail_wr,
	input  logic [ADDR_WIDTH-1:0] tail_len,
	input  logic [ADDR_WIDTH-1:0] l_start,
	input  logic [ADDR_WIDTH-1:0] l_len,
	input  logic [ID_WIDTH-1:0]   l_owner,
	input  logic                  l_used,
	input  logic                  l_sel,
	input  logic [ADDR_WIDTH-1:0] r_start,
	input  logic [ADDR_WIDTH-1:0] r_len,
	input  logic [ID_WIDTH-1:0]   r_owner,
	input  logic                  r_used,
	output logic [ADDR_WIDTH-1:0] start_q,
	output logic [ADDR_WIDTH-1:0] len_q,
	output logic [ID_WIDTH-1:0]   owner_q,
	output logic                  used_q
);

	// Split: cells past k+1 take the left entry, k+1 becomes the free remainder.
	// Merge (drop entry right of sel): cells right of sel take the right entry.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q  <= 1'b0;
			start_q <= '0;
			len_q   <= (IDX == 0) ? RESET_SIZE[ADDR_WIDTH-1:0] : '0;
		end else begin
			case (op)
				OP_INIT: begin
					used_q  <= 1'b0;
					start_q <= '0;
					len_q   <= (IDX == 0) ? init_len : '0;
				end
				OP_ALLOC: begin
					if (sel) begin
						used_q  <= 1'b1;
						owner_q <= pid;
						if (split)
							len_q <= req;
					end else if (split && l_sel) begin
						used_q  <= 1'b0;
						start_q <= l_start + req;
						len_q   <= l_len - req;
					end else if (split && right_of_sel) begin
						used_q  <= l_used;
						owner_q <= l_owner;
						start_q <= l_start;
						len_q   <= l_len;
					end
				end
				OP_FREE: begin
					if (sel)
						used_q <= 1'b0;
				end
				OP_MERGE: begin
					if (sel) begin
						len_q <= len_q + r_len;
					end else if (right_of_sel) begin
						used_q  <= r_used;
						owner_q <= r_owner;
						start_q <= r_start;
						len_q   <= r_len;
					end
				end
				OP_PACK: begin
					if (pack_wr) begin
						used_q  <= 1'b1;
						owner_q <= pack_owner;
						start_q <= pack_start;
						len_q   <= pack_len;
					end
				end
				OP_TAIL: begin
					if (tail_wr) begin
						used_q  <= 1'b0;
						start_q <= pack_start;
						len_q   <= tail_len;
					end
				end
				default: begin
				end
			endcase
		end
	end

endmodule
